[sv/json_string_unescape_utf8_unit_assert.svh]
`ifndef JSON_STRING_UNESCAPE_UTF8_UNIT_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_UNIT_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define JSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen
`define JSU_ASSERT_NEVER(lbl, expr, msg) \
  `JSU_ASSERT(lbl, !(expr), msg)

`endif

[sv/jsu_pkg.sv]
package jsu_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_BODY    = 3'd1,
    MODE_ESC     = 3'd2,
    MODE_HEX1    = 3'd3,
    MODE_HIGH    = 3'd4,
    MODE_HIGHESC = 3'd5,
    MODE_HEX2    = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    TERM_NONE   = 2'd0,
    TERM_CLOSED = 2'd1,
    TERM_FAILED = 2'd2
  } term_e;

  typedef struct packed {
    mode_e       mode;
    logic [15:0] hex_value;
    logic [1:0]  hex_count;
    logic [15:0] high_half;
    logic        bad_mark;
  } state_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      nbyte;
    term_e           term;
  } batch_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
  } utf8_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  localparam logic [7:0] CHAR_QUOTE  = 8'h22;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_U      = 8'h75;

  localparam logic [15:0] HIGH_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_LAST   = 16'hDFFF;
  localparam logic [20:0] PLANE1_BASE = 21'h010000;

  localparam state_t STATE_RESET = '{
    mode:      MODE_IDLE,
    hex_value: 16'h0000,
    hex_count: 2'd0,
    high_half: 16'h0000,
    bad_mark:  1'b0
  };

  function automatic hex_t hex_digit(input logic [7:0] b);
    hex_t r;
    r.ok    = 1'b0;
    r.value = b[3:0];
    if (b >= 8'h30 && b <= 8'h39) begin
      r.ok = 1'b1;
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r.ok    = 1'b1;
      r.value = b[3:0] + 4'd9;
    end
    return r;
  endfunction

  function automatic logic [7:0] escape_map(input logic [7:0] b);
    logic [7:0] r;
    unique case (b)
      8'h6E: r = 8'h0A;
      8'h74: r = 8'h09;
      8'h72: r = 8'h0D;
      8'h62: r = 8'h08;
      8'h66: r = 8'h0C;
      default: r = b;
    endcase
    return r;
  endfunction

  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t r;
    r.bytes = '0;
    if (cp < 21'h000080) begin
      r.len      = 3'd1;
      r.bytes[0] = cp[7:0];
    end else if (cp < 21'h000800) begin
      r.len      = 3'd2;
      r.bytes[0] = 8'hC0 | {3'b000, cp[10:6]};
      r.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
    end else if (cp < 21'h010000) begin
      r.len      = 3'd3;
      r.bytes[0] = 8'hE0 | {4'h0, cp[15:12]};
      r.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
      r.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
    end else begin
      r.len      = 3'd4;
      r.bytes[0] = 8'hF0 | {5'b00000, cp[20:18]};
      r.bytes[1] = 8'h80 | {2'b00, cp[17:12]};
      r.bytes[2] = 8'h80 | {2'b00, cp[11:6]};
      r.bytes[3] = 8'h80 | {2'b00, cp[5:0]};
    end
    return r;
  endfunction

endpackage

[sv/jsu_decode.sv]
module jsu_decode (
  input  jsu_pkg::state_t state_i,
  input  logic [7:0]      in_byte_i,
  input  logic            text_end_i,
  output jsu_pkg::state_t state_o,
  output jsu_pkg::batch_t batch_o
);
  import jsu_pkg::*;

  state_t      nxt;
  hex_t        hd;
  logic [15:0] hv_shift;
  logic [20:0] pair_cp;
  logic [20:0] high_part;
  logic [15:0] low_part;
  logic        cp_en;
  logic [20:0] cp;
  logic        byte_en;
  logic [7:0]  byte_val;
  term_e       term;
  logic        done;
  utf8_t       enc;
  logic [2:0]  len;

  assign hd        = hex_digit(in_byte_i);
  assign hv_shift  = {state_i.hex_value[11:0], hd.value};
  assign high_part = ({5'b00000, state_i.high_half} - {5'b00000, HIGH_FIRST}) << 10;
  assign low_part  = hv_shift - LOW_FIRST;
  assign pair_cp   = PLANE1_BASE + high_part + {5'b00000, low_part};

  always_comb begin
    nxt      = state_i;
    cp_en    = 1'b0;
    cp       = '0;
    byte_en  = 1'b0;
    byte_val = '0;
    term     = TERM_NONE;
    done     = 1'b0;

    unique case (state_i.mode)
      MODE_BODY: begin
        if (in_byte_i == CHAR_QUOTE) begin
          term = state_i.bad_mark ? TERM_FAILED : TERM_CLOSED;
          done = 1'b1;
        end else if (in_byte_i == CHAR_BSLASH) begin
          nxt.mode = MODE_ESC;
        end else begin
          byte_en  = 1'b1;
          byte_val = in_byte_i;
        end
      end
      MODE_ESC: begin
        if (in_byte_i == CHAR_U) begin
          nxt.mode      = MODE_HEX1;
          nxt.hex_value = '0;
          nxt.hex_count = '0;
        end else begin
          byte_en  = 1'b1;
          byte_val = escape_map(in_byte_i);
          nxt.mode = MODE_BODY;
        end
      end
      MODE_HEX1: begin
        if (!hd.ok) begin
          byte_en      = 1'b1;
          nxt.bad_mark = 1'b1;
          nxt.mode     = MODE_BODY;
        end else begin
          nxt.hex_value = hv_shift;
          if (state_i.hex_count == 2'd3) begin
            nxt.hex_count = '0;
            if (hv_shift >= HIGH_FIRST && hv_shift <= HIGH_LAST) begin
              nxt.high_half = hv_shift;
              nxt.mode      = MODE_HIGH;
            end else begin
              cp_en    = 1'b1;
              cp       = {5'b00000, hv_shift};
              nxt.mode = MODE_BODY;
            end
          end else begin
            nxt.hex_count = state_i.hex_count + 2'd1;
          end
        end
      end
      MODE_HIGH: begin
        if (in_byte_i == CHAR_BSLASH) begin
          nxt.mode = MODE_HIGHESC;
        end else begin
          cp_en    = 1'b1;
          cp       = {5'b00000, state_i.high_half};
          nxt.mode = MODE_BODY;
          if (in_byte_i == CHAR_QUOTE) begin
            term = state_i.bad_mark ? TERM_FAILED : TERM_CLOSED;
            done = 1'b1;
          end else begin
            byte_en  = 1'b1;
            byte_val = in_byte_i;
          end
        end
      end
      MODE_HIGHESC: begin
        if (in_byte_i == CHAR_U) begin
          nxt.mode      = MODE_HEX2;
          nxt.hex_value = '0;
          nxt.hex_count = '0;
        end else begin
          cp_en    = 1'b1;
          cp       = {5'b00000, state_i.high_half};
          byte_en  = 1'b1;
          byte_val = escape_map(in_byte_i);
          nxt.mode = MODE_BODY;
        end
      end
      MODE_HEX2: begin
        if (!hd.ok) begin
          cp_en        = 1'b1;
          cp           = {5'b00000, state_i.high_half};
          nxt.bad_mark = 1'b1;
          nxt.mode     = MODE_BODY;
        end else begin
          nxt.hex_value = hv_shift;
          if (state_i.hex_count == 2'd3) begin
            nxt.hex_count = '0;
            cp_en         = 1'b1;
            if (hv_shift >= LOW_FIRST && hv_shift <= LOW_LAST &&
                state_i.high_half >= HIGH_FIRST) begin
              cp = pair_cp;
            end else begin
              cp = {5'b00000, state_i.high_half};
            end
            nxt.mode = MODE_BODY;
          end else begin
            nxt.hex_count = state_i.hex_count + 2'd1;
          end
        end
      end
      default: begin
        if (in_byte_i == CHAR_QUOTE && !text_end_i) begin
          nxt.mode = MODE_BODY;
        end else begin
          term = TERM_FAILED;
          done = 1'b1;
        end
      end
    endcase

    // text ends inside the literal: flush pending escape, then fail
    if (text_end_i && !done) begin
      if (nxt.mode == MODE_HEX1) begin
        cp_en = 1'b1;
        cp    = {5'b00000, nxt.hex_value};
      end else if (nxt.mode == MODE_HIGH || nxt.mode == MODE_HIGHESC ||
                   nxt.mode == MODE_HEX2) begin
        cp_en = 1'b1;
        cp    = {5'b00000, nxt.high_half};
      end
      term = TERM_FAILED;
      done = 1'b1;
    end

    if (done) begin
      nxt = STATE_RESET;
    end
  end

  assign enc = utf8_encode(cp);

  always_comb begin
    batch_o.bytes = cp_en ? enc.bytes : '0;
    len           = cp_en ? enc.len : 3'd0;
    if (byte_en) begin
      batch_o.bytes[len[1:0]] = byte_val;
    end
    batch_o.nbyte = len + {2'b00, byte_en};
    batch_o.term  = term;
  end

  assign state_o = nxt;

endmodule

[sv/json_string_unescape_utf8_unit.sv]
// the first result of a request is shown in the cycle after the request is accepted
// throughput: one request per cycle while each yields at most one result and out_stall_i is low
// a request yielding several results holds the input stalled while the single result register
// drains them, one result per cycle while out_stall_i is low
// reset: clears all pending results and returns to waiting for an opening quote
module json_string_unescape_utf8_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       text_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       closed_o,
  output logic       failed_o
);
  import jsu_pkg::*;

  state_t          state_q;
  state_t          state_d;
  batch_t          batch_d;
  logic [3:0][7:0] bytes_q;
  logic [2:0]      nbyte_q;
  term_e           term_q;
  logic            last_result;
  logic            in_fire;
  logic            out_fire;

  jsu_decode u_decode (
    .state_i    (state_q),
    .in_byte_i  (in_byte_i),
    .text_end_i (text_end_i),
    .state_o    (state_d),
    .batch_o    (batch_d)
  );

  assign out_valid_o = (nbyte_q != 3'd0) || (term_q != TERM_NONE);
  assign last_result = ((nbyte_q == 3'd1) && (term_q == TERM_NONE)) ||
                       ((nbyte_q == 3'd0) && (term_q != TERM_NONE));
  assign in_stall_o  = out_valid_o && !(last_result && !out_stall_i);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_fire    = out_valid_o && !out_stall_i;

  assign byte_valid_o = (nbyte_q != 3'd0);
  assign out_byte_o   = byte_valid_o ? bytes_q[0] : 8'h00;
  assign closed_o     = !byte_valid_o && (term_q == TERM_CLOSED);
  assign failed_o     = !byte_valid_o && (term_q == TERM_FAILED);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
      nbyte_q <= 3'd0;
      term_q  <= TERM_NONE;
    end else if (in_fire) begin
      state_q <= state_d;
      nbyte_q <= batch_d.nbyte;
      term_q  <= batch_d.term;
    end else if (out_fire) begin
      if (nbyte_q != 3'd0) begin
        nbyte_q <= nbyte_q - 3'd1;
      end else begin
        term_q <= TERM_NONE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      bytes_q <= batch_d.bytes;
    end else if (out_fire && (nbyte_q != 3'd0)) begin
      bytes_q <= {8'h00, bytes_q[3:1]};
    end
  end

endmodule

[sv/jsu_checker.sv]
`include "json_string_unescape_utf8_unit_assert.svh"

module jsu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] in_byte_i,
  input logic       text_end_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       byte_valid_o,
  input logic       closed_o,
  input logic       failed_o
);

  `JSU_ASSERT(a_in_hold, in_valid_i && in_stall_o |=> in_valid_i && $stable(in_byte_i) && $stable(text_end_i), "stalled request changed")

  `JSU_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) && $stable(closed_o) && $stable(failed_o), "stalled result changed")

  `JSU_ASSERT(a_one_kind, out_valid_o |-> $onehot({byte_valid_o, closed_o, failed_o}), "result is not exactly one of byte closed failed")

  `JSU_ASSERT_NEVER(a_term_zero, out_valid_o && !byte_valid_o && (out_byte_o != 8'h00), "terminal result carries a nonzero byte")

  `JSU_ASSERT(a_stall_back, out_valid_o && out_stall_i |-> in_stall_o, "request taken while result register is blocked")

endmodule

bind json_string_unescape_utf8_unit jsu_checker u_jsu_checker (.*);
